// File: design/imfv_pkg.sv
// Shared types, character constants and character-class functions for the IRC field validator.
package imfv_pkg;

    // Field kinds carried in the low bits of tuser.
    typedef enum logic [3:0] {
        KIND_NICK     = 4'd0,
        KIND_USER     = 4'd1,
        KIND_HOST     = 4'd2,
        KIND_ORIGIN   = 4'd3,
        KIND_COMMAND  = 4'd4,
        KIND_MIDDLE   = 4'd5,
        KIND_TRAILING = 4'd6,
        KIND_CHANNEL  = 4'd7,
        KIND_MASK     = 4'd8,
        KIND_CHSTRING = 4'd9
    } kind_t;

    // Character constants used by the grammar rules.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_BEL   = 8'h07;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LBRK  = 8'h5B;
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_RBRK  = 8'h5D;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_TICK  = 8'h60;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;

    // Highest byte position tracked; the counter saturates here.
    localparam logic [1:0] POS_MAX = 2'd3;

    // One input item.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_byte;
        logic       is_last;
        logic       is_empty;
    } imfv_item_t;

    // Per-field running state.
    typedef struct packed {
        logic [1:0] position;
        logic [7:0] previous_byte;
        logic       host_path_ok;
        logic       other_path_ok;
        logic       numeric_command;
    } imfv_state_t;

    localparam imfv_state_t STATE_RESET = '{
        position:        2'd0,
        previous_byte:   CHAR_NUL,
        host_path_ok:    1'b1,
        other_path_ok:   1'b1,
        numeric_command: 1'b0
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return c inside {CHAR_DASH, CHAR_LBRK, CHAR_RBRK, CHAR_BSL, CHAR_TICK,
                         CHAR_CARET, CHAR_LBRACE, CHAR_RBRACE};
    endfunction

    function automatic logic is_nonwhite(input logic [7:0] c);
        return !(c inside {CHAR_SPACE, CHAR_NUL, CHAR_CR, CHAR_LF});
    endfunction

    function automatic logic is_chstring(input logic [7:0] c);
        return is_nonwhite(c) && (c != CHAR_BEL) && (c != CHAR_COMMA);
    endfunction

    // Judges a host byte b given the byte after it, if there is one.
    function automatic logic host_inner_ok(input logic [7:0] b, input logic [7:0] nxt,
                                           input logic nxt_exists);
        logic result;
        if (b == CHAR_DOT) begin
            result = nxt_exists && is_alpha(nxt);
        end else if (nxt_exists && (nxt == CHAR_DOT)) begin
            result = is_alnum(b);
        end else begin
            result = is_alnum(b) || (b == CHAR_DASH);
        end
        return result;
    endfunction

endpackage

// File: design/imfv_rules.sv
// Per-byte grammar checks: verdict for the current item and the next field state.
module imfv_rules
    import imfv_pkg::*;
(
    input  imfv_item_t  item,
    input  imfv_state_t state,
    output imfv_state_t state_next,
    output logic        ends_field,
    output logic        field_valid
);

    logic [7:0] c;
    logic [1:0] p;
    logic       numeric;
    logic       host_byte;
    logic       other_byte;
    logic       hok;
    logic       ook;

    assign c = item.char_byte;
    assign p = state.position;

    // A command is numeric when its first byte is a digit.
    assign numeric = (p == 2'd0) ? ((item.kind == KIND_COMMAND) && is_digit(c))
                                 : state.numeric_command;

    // Host rule with one byte of lookahead.
    always_comb begin
        if (p == 2'd0) begin
            host_byte = is_alpha(c);
        end else begin
            host_byte = p[1] ? host_inner_ok(state.previous_byte, c, 1'b1) : 1'b1;
            if (item.is_last) begin
                host_byte = host_byte && host_inner_ok(c, CHAR_NUL, 1'b0);
            end
        end
    end

    // Rule of the field kind; origin uses the nick rule here.
    always_comb begin
        case (item.kind)
            KIND_NICK, KIND_ORIGIN: begin
                other_byte = (p == 2'd0) ? is_alpha(c) : (is_alnum(c) || is_special(c));
            end
            KIND_USER: begin
                other_byte = is_nonwhite(c);
            end
            KIND_HOST: begin
                other_byte = 1'b1;
            end
            KIND_COMMAND: begin
                if (p == 2'd0) begin
                    other_byte = is_alpha(c) || (numeric && !item.is_last);
                end else if (numeric) begin
                    if (item.is_last && (p < 2'd2)) begin
                        other_byte = 1'b0;
                    end else begin
                        other_byte = (p <= 2'd2) ? is_digit(c) : 1'b1;
                    end
                end else begin
                    other_byte = is_alpha(c);
                end
            end
            KIND_MIDDLE: begin
                other_byte = (p == 2'd0) ? ((c != CHAR_COLON) && is_nonwhite(c))
                                         : is_nonwhite(c);
            end
            KIND_TRAILING: begin
                other_byte = (c != CHAR_NUL) && (c != CHAR_CR) && (c != CHAR_LF);
            end
            KIND_CHANNEL: begin
                other_byte = (p == 2'd0) ? ((c == CHAR_HASH) || (c == CHAR_AMP))
                                         : is_chstring(c);
            end
            KIND_MASK: begin
                other_byte = (p == 2'd0) ? ((c == CHAR_HASH) || (c == CHAR_DOLLAR))
                                         : is_chstring(c);
            end
            KIND_CHSTRING: begin
                other_byte = is_chstring(c);
            end
            default: begin
                other_byte = 1'b0;
            end
        endcase
    end

    assign hok = state.host_path_ok && host_byte;
    assign ook = state.other_path_ok && other_byte;

    assign ends_field = item.is_empty || item.is_last;

    // Verdict for a field that ends with this item.
    always_comb begin
        if (item.is_empty) begin
            field_valid = (item.kind == KIND_TRAILING) || (item.kind == KIND_CHSTRING);
        end else if (item.kind == KIND_HOST) begin
            field_valid = hok;
        end else if (item.kind == KIND_ORIGIN) begin
            field_valid = hok || ook;
        end else begin
            field_valid = ook;
        end
    end

    // State for the next byte; a finished field starts over.
    always_comb begin
        if (ends_field) begin
            state_next = STATE_RESET;
        end else begin
            state_next.position        = (p == POS_MAX) ? POS_MAX : p + 2'd1;
            state_next.previous_byte   = c;
            state_next.host_path_ok    = hok;
            state_next.other_path_ok   = ook;
            state_next.numeric_command = numeric;
        end
    end

endmodule

// File: design/irc_message_field_validator.sv
// Top level of the IRC message field validator: input register, field state and result register.
// The block takes one byte of an IRC message field per item, tagged with its field kind, and
// gives one verdict item when the field ends (on tlast, or at once for an empty field). It
// accepts one item every clock cycle unless its held item ends a field while a result waits; a
// verdict is registered when the item that ends its field leaves the input register. The field
// state (position, previous byte and pass flags) is rewritten for each byte. A result waiting
// in the output register does not stop bytes that end no field from flowing through.
module irc_message_field_validator
    import imfv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tlast,   // is_last
    input  logic [4:0] s_tuser,   // [3:0] kind, [4] is_empty
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] field_valid, [7:1] zero
);

    logic        s1_valid_reg;
    imfv_item_t  s1_item_reg;
    imfv_state_t state_reg;
    imfv_state_t state_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        m_data_reg;
    logic        ends_field;
    logic        field_valid;
    logic        out_free;
    logic        s1_fire;
    logic        s_fire;

    // Grammar checks for the registered item.
    imfv_rules u_rules (
        .item        (s1_item_reg),
        .state       (state_reg),
        .state_next  (state_next),
        .ends_field  (ends_field),
        .field_valid (field_valid)
    );

    // Handshake: the held item moves on unless it ends a field while the result waits.
    assign out_free = !m_valid_reg || m_tready;
    assign s1_fire  = s1_valid_reg && (!ends_field || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_fire   = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_item_reg <= '{kind:      kind_t'(s_tuser[3:0]),
                             char_byte: s_tdata,
                             is_last:   s_tlast,
                             is_empty:  s_tuser[4]};
        end
    end

    // Field state, updated once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (s1_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (s1_fire && ends_field) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && ends_field) begin
            m_data_reg <= field_valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

    // A field end always produces a result item in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && ends_field) |=> m_valid_reg)
        else $error("field end did not produce a result item");

    // A waiting result is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !(s1_fire && ends_field))
        else $error("pending result overwritten");

    // The field state starts over after each verdict.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && ends_field) |=> (state_reg == STATE_RESET))
        else $error("field state not cleared after verdict");

    // An empty field passes only for trailing and chstring kinds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_item_reg.is_empty && (s1_item_reg.kind != KIND_TRAILING)
         && (s1_item_reg.kind != KIND_CHSTRING)) |=> !m_data_reg)
        else $error("empty field accepted for a kind that needs characters");

    // Position only grows by one, saturates at POS_MAX or returns to zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire |=> ((state_reg.position == 2'd0)
                     || (state_reg.position == POS_MAX)
                     || (state_reg.position == $past(state_reg.position) + 2'd1)))
        else $error("position counter jumped");

endmodule

// File: verif/tb_irc_message_field_validator.sv
// Self-checking testbench for the IRC message field validator with its own verdict predictor.
`timescale 1ns / 1ps

module tb_irc_message_field_validator;
    import imfv_pkg::*;

    // Kinds with no meaning, used to reach the upper codes of the kind field.
    localparam logic [3:0] KIND_UNUSED_LO = 4'd10;
    localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

    localparam int TOTAL_ITEMS = 1600;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;

    localparam string ALPHA = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string ALNUM =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    localparam string NICK_TAIL =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-[]\\`^{}";
    localparam string HOST_TAIL =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       last;
        logic       empty;
    } byte_item_t;

    // A directed row may carry a verdict typed in by hand.
    typedef struct {
        byte_item_t item;
        logic       fixed;
        logic       val;
    } dir_row_t;

    typedef struct {
        logic fixed;
        logic val;
    } fixed_note_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] char_byte
    logic       s_tlast;   // is_last
    logic [4:0] s_tuser;   // [3:0] kind, [4] is_empty
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [0] field_valid, [7:1] zero

    // Expected verdicts in arrival order, and hand-typed notes per offered item.
    logic        verdict_q[$];
    fixed_note_t fixed_q[$];

    int accepted = 0;
    int items_sent = 0;
    int err_count = 0;
    int hold_request = 0;
    logic no_idle = 1'b0;

    // Predictor state for the field in progress.
    logic [1:0] fld_pos = 2'd0;
    logic [7:0] prev_ch = CHAR_NUL;
    logic       host_ok = 1'b1;
    logic       rule_ok = 1'b1;
    logic       numeric_cmd = 1'b0;

    dir_row_t dir_rows [25] = '{
        '{'{KIND_NICK,      "a",   1'b1, 1'b0}, 1'b1, 1'b1},
        '{'{KIND_TRAILING,  8'hFF, 1'b0, 1'b1}, 1'b1, 1'b1},
        '{'{KIND_CHSTRING,  8'h00, 1'b1, 1'b1}, 1'b1, 1'b1},
        '{'{KIND_NICK,      "a",   1'b1, 1'b1}, 1'b1, 1'b0},
        '{'{KIND_UNUSED_HI, "a",   1'b1, 1'b0}, 1'b1, 1'b0},
        '{'{KIND_UNUSED_LO, "a",   1'b1, 1'b0}, 1'b1, 1'b0},
        '{'{KIND_COMMAND,   "1",   1'b0, 1'b0}, 1'b0, 1'b0},
        '{'{KIND_COMMAND,   "2",   1'b0, 1'b0}, 1'b0, 1'b0},
        '{'{KIND_COMMAND,   "3",   1'b1, 1'b0}, 1'b1, 1'b1},
        '{'{KIND_COMMAND,   "1",   1'b0, 1'b0}, 1'b0, 1'b0},
        '{'{KIND_COMMAND,   "2",   1'b1, 1'b0}, 1'b1, 1'b0},
        '{'{KIND_HOST,      "a",   1'b0, 1'b0}, 1'b0, 1'b0},
        '{'{KIND_HOST,      ".",   1'b1, 1'b0}, 1'b1, 1'b0},
        '{'{KIND_HOST,      "a",   1'b0, 1'b0}, 1'b0, 1'b0},
        '{'{KIND_HOST,      ".",   1'b0, 1'b0}, 1'b0, 1'b0},
        '{'{KIND_HOST,      "b",   1'b1, 1'b0}, 1'b1, 1'b1},
        '{'{KIND_ORIGIN,    "a",   1'b0, 1'b0}, 1'b0, 1'b0},
        '{'{KIND_ORIGIN,    "[",   1'b1, 1'b0}, 1'b1, 1'b1},
        '{'{KIND_NICK,      8'h00, 1'b1, 1'b0}, 1'b1, 1'b0},
        '{'{KIND_USER,      8'hFF, 1'b1, 1'b0}, 1'b1, 1'b1},
        '{'{KIND_MIDDLE,    ":",   1'b1, 1'b0}, 1'b1, 1'b0},
        '{'{KIND_CHANNEL,   "#",   1'b1, 1'b0}, 1'b1, 1'b1},
        '{'{KIND_MASK,      "$",   1'b1, 1'b0}, 1'b1, 1'b1},
        '{'{KIND_NICK,      "a",   1'b0, 1'b0}, 1'b0, 1'b0},
        '{'{KIND_CHANNEL,   "b",   1'b1, 1'b0}, 1'b0, 1'b0}
    };

    irc_message_field_validator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Character classes of the grammar.
    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return is_letter(c) || is_numeral(c);
    endfunction

    function automatic logic is_nick_extra(input logic [7:0] c);
        return c inside {CHAR_DASH, CHAR_LBRK, CHAR_RBRK, CHAR_BSL, CHAR_TICK,
                         CHAR_CARET, CHAR_LBRACE, CHAR_RBRACE};
    endfunction

    function automatic logic is_visible(input logic [7:0] c);
        return (c != CHAR_SPACE) && (c != CHAR_NUL) && (c != CHAR_CR) && (c != CHAR_LF);
    endfunction

    function automatic logic is_chan_char(input logic [7:0] c);
        return is_visible(c) && (c != CHAR_BEL) && (c != CHAR_COMMA);
    endfunction

    // Host rule for byte b, knowing the byte that follows it, if any.
    function automatic logic dot_rule_ok(input logic [7:0] b, input logic [7:0] nxt,
                                         input logic has_nxt);
        if (b == CHAR_DOT) begin
            return has_nxt && is_letter(nxt);
        end
        return is_word_char(b) || (b == CHAR_DASH && !(has_nxt && nxt == CHAR_DOT));
    endfunction

    // The previous byte is judged now that its successor is known; a last byte is
    // judged as if nothing followed.
    function automatic logic host_char_ok(input logic [1:0] p, input logic [7:0] c,
                                          input logic last);
        if (p == 2'd0) begin
            return is_letter(c);
        end
        return (p < 2'd2 || dot_rule_ok(prev_ch, c, 1'b1)) &&
               (!last || dot_rule_ok(c, CHAR_NUL, 1'b0));
    endfunction

    function automatic logic kind_char_ok(input logic [3:0] kind, input logic [1:0] p,
                                          input logic [7:0] c, input logic last,
                                          input logic num);
        case (kind)
            KIND_NICK, KIND_ORIGIN: begin
                return (p == 2'd0) ? is_letter(c) : (is_word_char(c) || is_nick_extra(c));
            end
            KIND_USER: return is_visible(c);
            KIND_HOST: return 1'b1;
            KIND_COMMAND: begin
                if (p == 2'd0) begin
                    return is_letter(c) || (num && !last);
                end
                if (!num) begin
                    return is_letter(c);
                end
                // A numeric command shorter than three digits fails at its end.
                if (last && p < 2'd2) begin
                    return 1'b0;
                end
                return (p > 2'd2) || is_numeral(c);
            end
            KIND_MIDDLE: return is_visible(c) && !(p == 2'd0 && c == CHAR_COLON);
            KIND_TRAILING: return !(c inside {CHAR_NUL, CHAR_CR, CHAR_LF});
            KIND_CHANNEL: begin
                return (p == 2'd0) ? (c == CHAR_HASH || c == CHAR_AMP) : is_chan_char(c);
            end
            KIND_MASK: begin
                return (p == 2'd0) ? (c == CHAR_HASH || c == CHAR_DOLLAR) : is_chan_char(c);
            end
            KIND_CHSTRING: return is_chan_char(c);
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_field();
        fld_pos     = 2'd0;
        prev_ch     = CHAR_NUL;
        host_ok     = 1'b1;
        rule_ok     = 1'b1;
        numeric_cmd = 1'b0;
    endfunction

    // Advances the field state by one byte; returns 1 when the field ends with a verdict.
    function automatic logic field_step(input byte_item_t it, output logic verdict);
        logic num;
        logic h;
        logic o;
        verdict = 1'b0;
        if (it.empty) begin
            verdict = (it.kind == KIND_TRAILING) || (it.kind == KIND_CHSTRING);
            clear_field();
            return 1'b1;
        end
        num = (fld_pos == 2'd0) ? (it.kind == KIND_COMMAND && is_numeral(it.ch)) : numeric_cmd;
        h = host_ok && host_char_ok(fld_pos, it.ch, it.last);
        o = rule_ok && kind_char_ok(it.kind, fld_pos, it.ch, it.last, num);
        if (it.last) begin
            case (it.kind)
                KIND_HOST: verdict = h;
                KIND_ORIGIN: verdict = h || o;
                default: verdict = o;
            endcase
            clear_field();
            return 1'b1;
        end
        fld_pos     = (fld_pos == POS_MAX) ? POS_MAX : fld_pos + 2'd1;
        prev_ch     = it.ch;
        host_ok     = h;
        rule_ok     = o;
        numeric_cmd = num;
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    // Watch both handshakes at the rising edge.
    always @(posedge aclk) begin : watch_ports
        logic        has_verdict;
        logic        verdict;
        logic        want;
        fixed_note_t note;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch($sformatf("verdict %0b with none expected", m_tdata[0]));
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want) begin
                        report_mismatch($sformatf("field_valid %0b, expected %0b",
                                                  m_tdata[0], want));
                    end
                    if (m_tdata[7:1] !== 7'd0) begin
                        report_mismatch($sformatf("padding bits %h not zero", m_tdata[7:1]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                note = fixed_q.pop_front();
                has_verdict = field_step('{s_tuser[3:0], s_tdata, s_tlast, s_tuser[4]},
                                         verdict);
                if (has_verdict) begin
                    verdict_q.push_back(note.fixed ? note.val : verdict);
                end
                accepted++;
            end
        end
    end

    // Receiver: random stalls, a stall-free stretch, and a long hold-off on request.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 24);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] pick_from(input string pool);
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    // Offer one item, with random gaps before it, and wait until it is taken.
    task automatic send_item(input byte_item_t it, input logic fixed, input logic val);
        int target;
        while (!no_idle && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        fixed_q.push_back('{fixed, val});
        s_tvalid <= 1'b1;
        s_tdata  <= it.ch;
        s_tlast  <= it.last;
        s_tuser  <= {it.empty, it.kind};
        target = accepted + 1;
        do @(negedge aclk); while (accepted < target);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Build the bytes of one field, mostly well formed for its kind.
    task automatic make_field(output logic [3:0] kind, output logic empty,
                              ref logic [7:0] body[$]);
        int n;
        int labels;
        logic [7:0] b;
        body.delete();
        kind = ($urandom_range(99) < 6) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(9));
        empty = ($urandom_range(99) < 5);
        if (empty) begin
            return;
        end
        if (kind == KIND_ORIGIN && $urandom_range(1) == 0) begin
            // Origin as a host name.
            labels = $urandom_range(1, 3);
            for (int l = 0; l < labels; l++) begin
                n = $urandom_range(1, 4);
                if (l > 0) body.push_back(CHAR_DOT);
                body.push_back(pick_from(ALPHA));
                for (int i = 1; i < n; i++) begin
                    body.push_back(pick_from(i == n - 1 ? ALNUM : HOST_TAIL));
                end
            end
        end else begin
            case (kind)
                KIND_NICK, KIND_ORIGIN: begin
                    n = $urandom_range(1, 9);
                    body.push_back(pick_from(ALPHA));
                    for (int i = 1; i < n; i++) body.push_back(pick_from(NICK_TAIL));
                end
                KIND_HOST: begin
                    labels = $urandom_range(1, 3);
                    for (int l = 0; l < labels; l++) begin
                        n = $urandom_range(1, 4);
                        if (l > 0) body.push_back(CHAR_DOT);
                        body.push_back(pick_from(ALPHA));
                        for (int i = 1; i < n; i++) begin
                            body.push_back(pick_from(i == n - 1 ? ALNUM : HOST_TAIL));
                        end
                    end
                end
                KIND_USER: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(33, 255)));
                end
                KIND_COMMAND: begin
                    if ($urandom_range(1) == 0) begin
                        n = ($urandom_range(99) < 70) ? 3 : $urandom_range(1, 5);
                        for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(48, 57)));
                    end else begin
                        n = $urandom_range(1, 6);
                        for (int i = 0; i < n; i++) body.push_back(pick_from(ALPHA));
                    end
                end
                KIND_MIDDLE: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        do b = 8'($urandom_range(33, 255)); while (i == 0 && b == CHAR_COLON);
                        body.push_back(b);
                    end
                end
                KIND_TRAILING: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        do b = 8'($urandom_range(1, 255)); while (b == CHAR_CR || b == CHAR_LF);
                        body.push_back(b);
                    end
                end
                KIND_CHANNEL, KIND_MASK, KIND_CHSTRING: begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        do b = 8'($urandom_range(33, 255)); while (b == CHAR_COMMA);
                        body.push_back(b);
                    end
                    if (kind == KIND_CHANNEL) begin
                        body[0] = ($urandom_range(1) == 0) ? CHAR_HASH : CHAR_AMP;
                    end else if (kind == KIND_MASK) begin
                        body[0] = ($urandom_range(1) == 0) ? CHAR_HASH : CHAR_DOLLAR;
                    end
                end
                default: begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) body.push_back(8'($urandom_range(255)));
                end
            endcase
        end
        // Break some fields with one raw byte.
        if ($urandom_range(99) < 15) begin
            body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
        end
    endtask

    initial begin : stimulus
        logic [3:0] kind;
        logic [3:0] byte_kind;
        logic       empty;
        logic       lst;
        logic [7:0] body[$];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        s_tuser  = 5'd0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows: extremes, every kind and the special cases.
        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].val);
        end

        // Sender pauses until every verdict is back.
        wait_drained();

        // Receiver holds off while single-byte fields keep coming, so the block backs up.
        hold_request = HOLD_CYCLES;
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_item('{4'($urandom_range(9)), pick_from(ALPHA), 1'b1, 1'b0}, 1'b0, 1'b0);
        end
        no_idle = 1'b0;

        // Random fields, with a stretch free of idle cycles in the middle.
        while (items_sent < TOTAL_ITEMS) begin
            no_idle = (items_sent >= 600 && items_sent < 900);
            make_field(kind, empty, body);
            if (empty) begin
                send_item('{kind, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1},
                          1'b0, 1'b0);
            end else begin
                foreach (body[i]) begin
                    byte_kind = ($urandom_range(99) < 4) ? 4'($urandom_range(15)) : kind;
                    lst = (i == body.size() - 1) || ($urandom_range(99) < 2);
                    send_item('{byte_kind, body[i], lst, 1'b0}, 1'b0, 1'b0);
                end
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
